// File: hdl/als_pkg.sv
// Package: widths, types and constants shared by the auto-levels stretch block.
package als_pkg;
   localparam int COUNT_BITS_DEFAULT = 22;
   localparam int CHANS = 3;
   localparam int BINS = 256;
   localparam int BIN_BITS = 8;
   localparam int CSR_DATA_BITS = 23;
   localparam int CSR_ADDR_BITS = 1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LOW_CLIP = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HIGH_CLIP = 1'b1;
   localparam logic REQ_MEASURE = 1'b0;
   localparam logic REQ_CORRECT = 1'b1;

   typedef struct packed {
      logic [BIN_BITS-1:0] clip_lo;
      logic [BIN_BITS-1:0] clip_hi;
      logic [BIN_BITS-1:0] occ_lo;
      logic [BIN_BITS-1:0] occ_hi;
   } bounds_type;

   typedef struct packed {
      logic                req_type;
      logic [BIN_BITS-1:0] chan0_in;
      logic [BIN_BITS-1:0] chan1_in;
      logic [BIN_BITS-1:0] chan2_in;
      logic                last_pixel;
   } req_type_type;

   typedef struct packed {
      logic [BIN_BITS-1:0] chan0_out;
      logic [BIN_BITS-1:0] chan1_out;
      logic [BIN_BITS-1:0] chan2_out;
   } rsp_type;

   // lane control from the sequencer
   typedef struct packed {
      logic                tally;      // count the byte held in tally_bin
      logic                clear;      // write zero at walk_addr
      logic                walk_rd;    // read walk_addr for the walk
      logic                walk_start; // reset running sums
      logic [BIN_BITS-1:0] walk_addr;
      logic                walk_dn;    // this walk goes from 255 down
   } lane_ctl_type;
endpackage

// File: hdl/als_if.sv
// Valid/ready channel interface carrying a typed payload.
interface als_if #(parameter type PAYLOAD_TYPE = logic) (input logic clock);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hdl/als_ram.sv
// Generic single-write, single-read RAM with registered read.
module als_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/als_lane.sv
// One channel lane: histogram RAM, tally update, bound walk and stretch mapping.
module als_lane #(
   parameter int COUNT_BITS = 22
) (
   input  logic                               clock,
   input  logic                               reset,
   input  als_pkg::lane_ctl_type              ctl,
   input  logic [als_pkg::BIN_BITS-1:0]       tally_bin,
   input  logic [als_pkg::CSR_DATA_BITS-1:0]  low_clip_count,
   input  logic [als_pkg::CSR_DATA_BITS-1:0]  high_clip_count,
   input  logic [als_pkg::BIN_BITS-1:0]       pix,
   input  logic                               map_start,
   output logic                               map_done,
   output logic [als_pkg::BIN_BITS-1:0]       pix_out
);
   import als_pkg::*;
   localparam int SUM_BITS = COUNT_BITS + BIN_BITS;
   localparam logic [COUNT_BITS-1:0] BIN_MAX = '1;

   logic [COUNT_BITS-1:0] rd_data;
   logic                  wr_en;
   logic [BIN_BITS-1:0]   wr_addr, rd_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS-1:0] rd_fix;

   // tally: read the bin, then write back its count plus one (saturating)
   logic                tally_ff;
   logic [BIN_BITS-1:0] tally_bin_ff;
   logic                rd_valid_ff, rd_dn_ff;
   logic [BIN_BITS-1:0] rd_addr_ff;
   logic [BIN_BITS-1:0] rd_addr_q_ff, byp_addr_ff;
   logic                byp_valid_ff;
   logic [COUNT_BITS-1:0] byp_data_ff;

   always_comb begin
      // forward a write that landed in the same cycle as the read
      rd_fix = (byp_valid_ff && byp_addr_ff == rd_addr_q_ff) ? byp_data_ff : rd_data;
      rd_addr = ctl.walk_rd ? ctl.walk_addr : tally_bin;
      wr_en = 1'b0;
      wr_addr = tally_bin_ff;
      wr_data = (rd_fix == BIN_MAX) ? rd_fix : rd_fix + 1'b1;
      if (ctl.clear) begin
         wr_en = 1'b1;
         wr_addr = ctl.walk_addr;
         wr_data = '0;
      end else if (tally_ff) begin
         wr_en = 1'b1;
      end
   end

   als_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         tally_ff <= ctl.tally;
         rd_valid_ff <= ctl.walk_rd;
         byp_valid_ff <= wr_en;
      end
      tally_bin_ff <= tally_bin;
      rd_addr_ff <= ctl.walk_addr;
      rd_dn_ff <= ctl.walk_dn;
      rd_addr_q_ff <= rd_addr;
      byp_addr_ff <= wr_addr;
      byp_data_ff <= wr_data;
   end

   // walk: running sum and first-hit flags
   logic [SUM_BITS-1:0] run_ff, run_in;
   logic                clip_hit_ff, occ_hit_ff;
   bounds_type          bnd_ff, bnd_in;
   logic                clip_hit_in, occ_hit_in;
   logic [SUM_BITS-1:0] thr;

   always_comb begin
      run_in = run_ff;
      clip_hit_in = clip_hit_ff;
      occ_hit_in = occ_hit_ff;
      bnd_in = bnd_ff;
      thr = rd_dn_ff ? SUM_BITS'(high_clip_count) : SUM_BITS'(low_clip_count);
      if (rd_valid_ff) begin
         run_in = run_ff + SUM_BITS'(rd_fix);
         if (!clip_hit_ff && run_in > thr) begin
            clip_hit_in = 1'b1;
            if (rd_dn_ff) bnd_in.clip_hi = rd_addr_ff;
            else bnd_in.clip_lo = rd_addr_ff;
         end
         if (!occ_hit_ff && rd_fix != '0) begin
            occ_hit_in = 1'b1;
            if (rd_dn_ff) bnd_in.occ_hi = rd_addr_ff;
            else bnd_in.occ_lo = rd_addr_ff;
         end
      end
      // the last read of a walk lands in the cycle that restarts the sums
      if (ctl.walk_start) begin
         run_in = '0;
         clip_hit_in = 1'b0;
         occ_hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_ff <= '{clip_lo: 8'd0, clip_hi: 8'd255, occ_lo: 8'd0, occ_hi: 8'd255};
         clip_hit_ff <= 1'b0;
         occ_hit_ff <= 1'b0;
      end else begin
         bnd_ff <= bnd_in;
         clip_hit_ff <= clip_hit_in;
         occ_hit_ff <= occ_hit_in;
      end
      run_ff <= run_in;
   end

   // mapping: multiply, then bit-serial restoring divide, then saturate
   localparam int NUM_BITS = 17;
   localparam int CNT_BITS = 5;
   logic signed [9:0]  c_off;
   logic signed [9:0]  span;
   logic signed [18:0] prod;
   logic               busy_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [NUM_BITS-1:0] quo_ff;
   logic [8:0]          rem_ff;
   logic [8:0]          den_ff;
   logic                neg_ff, zero_den_ff, below_ff, above_ff;
   logic [BIN_BITS-1:0] lo_ff;
   logic [9:0]          rem_sh;
   logic signed [19:0]  q_s, r_full;

   always_comb begin
      c_off = $signed({2'b0, pix}) - $signed({2'b0, bnd_ff.occ_lo});
      span = $signed({2'b0, bnd_ff.clip_hi}) - $signed({2'b0, bnd_ff.clip_lo});
      prod = 19'(c_off) * 19'(span);
      rem_sh = {rem_ff, quo_ff[NUM_BITS-1]};
   end

   logic signed [9:0] den_s;
   always_comb den_s = $signed({2'b0, bnd_ff.occ_hi}) - $signed({2'b0, bnd_ff.occ_lo});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         map_done <= 1'b0;
      end else begin
         map_done <= 1'b0;
         if (map_start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_BITS'(NUM_BITS - 1)) begin
            busy_ff <= 1'b0;
            map_done <= 1'b1;
         end
      end
      if (map_start) begin
         cnt_ff <= '0;
         // magnitudes; sign restored after the divide
         quo_ff <= NUM_BITS'(prod < 0 ? -prod : prod);
         den_ff <= 9'(den_s < 0 ? -den_s : den_s);
         neg_ff <= (prod < 0) ^ (den_s < 0);
         zero_den_ff <= den_s == 0;
         below_ff <= pix < bnd_ff.clip_lo;
         above_ff <= pix > bnd_ff.clip_hi;
         lo_ff <= bnd_ff.clip_lo;
         rem_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= 9'(rem_sh - {1'b0, den_ff});
            quo_ff <= {quo_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[8:0];
            quo_ff <= {quo_ff[NUM_BITS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      q_s = neg_ff ? -$signed({3'b0, quo_ff}) : $signed({3'b0, quo_ff});
      r_full = zero_den_ff ? $signed({12'b0, lo_ff}) : q_s + $signed({12'b0, lo_ff});
      if (below_ff) pix_out = '0;
      else if (above_ff) pix_out = 8'd255;
      else if (r_full < 0) pix_out = '0;
      else if (r_full > 20'sd255) pix_out = 8'd255;
      else pix_out = r_full[7:0];
   end
endmodule

// File: hdl/als_seq.sv
// Sequencer: accepts items, drives tally, walks and clears, and merges lane results.
module als_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  als_pkg::req_type_type in_data,
   output als_pkg::lane_ctl_type ctl,
   output logic                  map_start,
   input  logic [als_pkg::CHANS-1:0] map_done,
   output logic                  out_load,
   output logic                  out_valid,
   input  logic                  out_ready
);
   import als_pkg::*;
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_UP    = 5'b00010,
      S_DN    = 5'b00100,
      S_CLEAR = 5'b01000,
      S_MAP   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [BIN_BITS:0]   addr_ff, addr_in;
   logic                out_valid_ff, out_valid_in;
   logic                done_ff, done_in;
   logic                accept, drain, map_all;

   assign accept = in_valid && in_ready;
   assign drain = addr_ff[BIN_BITS];
   assign map_all = &map_done;

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      out_valid_in = out_valid_ff && !out_ready;
      done_in = done_ff;
      out_load = 1'b0;
      in_ready = 1'b0;
      map_start = 1'b0;
      ctl = '0;
      ctl.walk_addr = addr_ff[BIN_BITS-1:0];
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            ctl.tally = accept && in_data.req_type == REQ_MEASURE;
            if (accept && in_data.req_type == REQ_CORRECT) begin
               map_start = 1'b1;
               state_in = S_MAP;
            end else if (accept && in_data.last_pixel) begin
               state_in = S_UP;
               addr_in = '0;
               ctl.walk_start = 1'b1;
            end
         end
         S_UP, S_DN: begin
            // a drain step after the last address lets the last read land
            ctl.walk_dn = state_ff == S_DN;
            ctl.walk_rd = !drain;
            ctl.walk_addr = (state_ff == S_DN) ? ~addr_ff[BIN_BITS-1:0]
                                               : addr_ff[BIN_BITS-1:0];
            addr_in = addr_ff + 1'b1;
            if (drain) begin
               ctl.walk_start = 1'b1;
               addr_in = '0;
               state_in = (state_ff == S_UP) ? S_DN : S_CLEAR;
            end
         end
         S_CLEAR: begin
            ctl.clear = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff[BIN_BITS-1:0] == BIN_BITS'(BINS - 1)) begin
               state_in = S_IDLE;
               addr_in = '0;
            end
         end
         S_MAP: begin
            // hold the mapped item until the result register is free
            if ((map_all || done_ff) && (!out_valid_ff || out_ready)) begin
               out_valid_in = 1'b1;
               out_load = 1'b1;
               done_in = 1'b0;
               state_in = S_IDLE;
            end else if (map_all) begin
               done_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         out_valid_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         out_valid_ff <= out_valid_in;
         done_ff <= done_in;
      end
   end
   assign out_valid = out_valid_ff;
endmodule

// File: hdl/auto_levels_stretch_unit.sv
// Top level of the auto-levels histogram stretch unit.
// channel  direction  payload
// req      in         req_type, chan0_in, chan1_in, chan2_in, last_pixel
// rsp      out        chan0_out, chan1_out, chan2_out
// csr      in         write of low_clip_count (0) or high_clip_count (1)
// Measure items are taken back to back; a last measure item then starts two
// walks per channel lane, up then down, then a clear of the histogram RAMs.
// A correct item is mapped by the 17-step divider in each lane.
// Reset is synchronous; a clear of the histogram RAMs follows reset
// before the first item is taken.
// A waiting result stalls a following correct item once its mapping is done,
// until rsp is taken; measure items pass.
module auto_levels_stretch_unit #(
   parameter int COUNT_BITS = als_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   als_if.sink                                 req,
   als_if.source                               rsp,
   input  logic                                csr_wr_en,
   input  logic [als_pkg::CSR_ADDR_BITS-1:0]   csr_index,
   input  logic [als_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import als_pkg::*;
   logic [CSR_DATA_BITS-1:0] low_ff, high_ff;
   lane_ctl_type             ctl;
   logic                     map_start;
   logic [CHANS-1:0]         map_done;
   logic                     out_load;
   logic [BIN_BITS-1:0]      pix [CHANS];
   logic [BIN_BITS-1:0]      pout [CHANS];
   logic [BIN_BITS-1:0]      pin_ff [CHANS];
   logic                     rsp_valid;
   logic                     sel_in;
   logic [BIN_BITS-1:0]      cur [CHANS];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         high_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOW_CLIP: low_ff <= csr_wdata;
            CSR_HIGH_CLIP: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   als_seq u_seq (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .ctl, .map_start, .map_done, .out_load,
      .out_valid(rsp_valid), .out_ready(rsp.ready)
   );
   assign sel_in = 1'b1;
   assign pix[0] = req.data.chan0_in;
   assign pix[1] = req.data.chan1_in;
   assign pix[2] = req.data.chan2_in;

   for (genvar g = 0; g < CHANS; g++) begin : g_lane
      always_comb cur[g] = sel_in ? pix[g] : pin_ff[g];
      always_ff @(posedge clock) pin_ff[g] <= pix[g];
      als_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
         .clock, .reset, .ctl, .tally_bin(cur[g]),
         .low_clip_count(low_ff), .high_clip_count(high_ff),
         .pix(cur[g]), .map_start,
         .map_done(map_done[g]), .pix_out(pout[g])
      );
   end

   // hold the merged result until taken
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= '{chan0_out: pout[0], chan1_out: pout[1], chan2_out: pout[2]};
      end
   end
   assign rsp.valid = rsp_valid;
   assign rsp.data = rsp_ff;
endmodule

// File: hdl/als_check.sv
// Port-level checker for the auto-levels stretch unit, with its bind.
module als_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [23:0] rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   a_no_accept_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && $past(rsp_valid && !rsp_ready) |-> !(req_valid && req_ready) ||
      $stable(rsp_data))
      else $error("result overwritten");
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind auto_levels_stretch_unit als_check u_check (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
